// File: design/fqrrb_pkg.sv
package fqrrb_pkg;

  // Default sizes of the queue storage.
  localparam int QUEUE_DEPTH_DEF = 128;
  localparam int LANES_DEF       = 4;

  // Fixed field widths.
  localparam int KIND_W  = 1;
  localparam int LANE_W  = 2;
  localparam int TAG_W   = 16;
  localparam int HOLD_W  = 4;
  localparam int ENTRY_W = TAG_W + HOLD_W;
  localparam int BURST_W = 8;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_ENQUEUE = 1'b0;
  localparam logic [KIND_W-1:0] KIND_SERVE   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_LANE  = 1'b1;

  // Reset value of the burst limit register.
  localparam logic [BURST_W-1:0] BURST_LIMIT_RST = 8'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input beat
    logic exec;     // update queues and issue the store access
    logic fill;     // load the output register
  } ctrl_cmd_t;

endpackage

// File: design/fqrrb_ctrl.sv
module fqrrb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fqrrb_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_FILL = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;
  logic   accept;

  // The output register can take a new beat when it is empty or being drained.
  assign out_free = !out_valid || !out_stall;

  // A new item is taken while idle, or in the cycle that loads the previous result.
  // Nothing is taken while reset is held.
  assign in_stall = rst || !((state == ST_IDLE) || ((state == ST_FILL) && out_free));
  assign accept   = in_valid && !in_stall;

  assign cmd.capture = accept;
  assign cmd.exec    = (state == ST_EXEC);
  assign cmd.fill    = (state == ST_FILL) && out_free;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_FILL;
      end
      ST_FILL: begin
        if (out_free) begin
          state_next = accept ? ST_EXEC : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output valid: set when a result is loaded, cleared when the beat is taken.
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.fill) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: design/fqrrb_datapath.sv
module fqrrb_datapath #(
  parameter int QUEUE_DEPTH = fqrrb_pkg::QUEUE_DEPTH_DEF,
  parameter int LANES       = fqrrb_pkg::LANES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  fqrrb_pkg::ctrl_cmd_t              cmd,
  input  logic                              cfg_we,
  input  logic [fqrrb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fqrrb_pkg::CFG_W-1:0]       cfg_data,
  input  logic [fqrrb_pkg::KIND_W-1:0]      kind,
  input  logic [fqrrb_pkg::LANE_W-1:0]      lane,
  input  logic [fqrrb_pkg::TAG_W-1:0]       entry_tag,
  input  logic [fqrrb_pkg::HOLD_W-1:0]      hold_time,
  output logic                              enqueue_ok,
  output logic                              grant_valid,
  output logic [fqrrb_pkg::LANE_W-1:0]      grant_lane,
  output logic [fqrrb_pkg::TAG_W-1:0]       grant_tag,
  output logic [fqrrb_pkg::HOLD_W-1:0]      grant_hold,
  output logic                              lane_switched
);

  localparam int IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int LSEL_W    = $clog2(LANES);
  localparam int DEPTH_ALL = LANES * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(DEPTH_ALL);
  // Lane numbers are handled in a five-bit space, wide enough for 2 * 16 - 1.
  localparam int LX_W      = 5;
  localparam logic [LX_W-1:0]   LANES_V    = LX_W'(LANES);
  localparam logic [IDX_W-1:0]  LAST_SLOT  = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT   = CNT_W'(QUEUE_DEPTH);
  localparam logic [ADDR_W-1:0] LANE_SPAN  = ADDR_W'(QUEUE_DEPTH);

  // Entry store, one region of QUEUE_DEPTH slots per lane.
  logic [fqrrb_pkg::ENTRY_W-1:0] store [DEPTH_ALL];
  logic [fqrrb_pkg::ENTRY_W-1:0] rd_data;

  // Per-lane queue pointers and fill counts.
  logic [IDX_W-1:0]  head [LANES];
  logic [IDX_W-1:0]  tail [LANES];
  logic [CNT_W-1:0]  count [LANES];

  // Turn state and configuration.
  logic [LSEL_W-1:0]             cur_lane;
  logic [fqrrb_pkg::BURST_W-1:0] served;
  logic [fqrrb_pkg::BURST_W-1:0] burst_limit;

  // Captured input beat.
  logic [fqrrb_pkg::KIND_W-1:0] kind_q;
  logic [fqrrb_pkg::LANE_W-1:0] lane_q;
  logic [fqrrb_pkg::TAG_W-1:0]  tag_q;
  logic [fqrrb_pkg::HOLD_W-1:0] hold_q;

  // Result held between the update cycle and the output load.
  logic                         res_enq_ok;
  logic                         res_grant;
  logic [fqrrb_pkg::LANE_W-1:0] res_lane;
  logic                         res_switched;

  // Decision signals.
  logic [LANES-1:0]  nonempty;
  logic [LANES-1:0]  full;
  logic [LX_W-1:0]   lane_x;
  logic [LSEL_W-1:0] enq_lane;
  logic              enq_ok;
  logic              stay;
  logic              search_found;
  logic [LSEL_W-1:0] search_sel;
  logic              found;
  logic [LSEL_W-1:0] sel;
  logic              switched;
  logic [LX_W-1:0]   sel_x;
  logic [LX_W-1:0]   start_x;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == LAST_SLOT) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LSEL_W-1:0] l,
                                                  input logic [IDX_W-1:0]  i);
    return ADDR_W'(l) * LANE_SPAN + ADDR_W'(i);
  endfunction

  // Per-lane status flags.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      nonempty[l] = (count[l] != '0);
      full[l]     = (count[l] == FULL_CNT);
    end
  end

  // Enqueue check: the lane must exist and have room.
  assign lane_x   = LX_W'(lane_q);
  assign enq_lane = lane_x[LSEL_W-1:0];
  assign enq_ok   = (lane_x < LANES_V) && !full[enq_lane];

  // Keep serving the current lane while it has entries and budget left.
  assign stay = nonempty[cur_lane] && (served < burst_limit);

  // Rotating search for the next non-empty lane, ending at the current lane.
  always_comb begin
    logic [LX_W-1:0] cand;
    search_found = 1'b0;
    search_sel   = cur_lane;
    for (int k = 1; k <= LANES; k++) begin
      cand = LX_W'(cur_lane) + LX_W'(k);
      if (cand >= LANES_V) begin
        cand = cand - LANES_V;
      end
      if (!search_found && nonempty[cand[LSEL_W-1:0]]) begin
        search_found = 1'b1;
        search_sel   = cand[LSEL_W-1:0];
      end
    end
  end

  assign found    = stay || search_found;
  assign sel      = stay ? cur_lane : search_sel;
  assign switched = stay ? (served == '0) : 1'b1;
  assign sel_x    = LX_W'(sel);

  assign wr_addr = slot_addr(enq_lane, tail[enq_lane]);
  assign rd_addr = slot_addr(sel, head[sel]);

  // Start lane reduced into the lane range.
  always_comb begin
    start_x = LX_W'(cfg_data[fqrrb_pkg::LANE_W-1:0]);
    if (start_x >= LANES_V) begin
      start_x = start_x - LANES_V;
    end
  end

  // Store access: one write for an enqueue or one registered read for a grant.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (kind_q == fqrrb_pkg::KIND_ENQUEUE) begin
        if (enq_ok) begin
          store[wr_addr] <= {tag_q, hold_q};
        end
      end else if (found) begin
        rd_data <= store[rd_addr];
      end
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= kind;
      lane_q <= lane;
      tag_q  <= entry_tag;
      hold_q <= hold_time;
    end
  end

  // Queue pointers, turn state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LANES; l++) begin
        head[l]  <= '0;
        tail[l]  <= '0;
        count[l] <= '0;
      end
      cur_lane    <= '0;
      served      <= '0;
      burst_limit <= fqrrb_pkg::BURST_LIMIT_RST;
    end else begin
      if (cmd.exec) begin
        if (kind_q == fqrrb_pkg::KIND_ENQUEUE) begin
          if (enq_ok) begin
            tail[enq_lane]  <= next_slot(tail[enq_lane]);
            count[enq_lane] <= count[enq_lane] + CNT_W'(1);
          end
        end else if (found) begin
          head[sel]  <= next_slot(head[sel]);
          count[sel] <= count[sel] - CNT_W'(1);
          cur_lane   <= sel;
          served     <= stay ? served + fqrrb_pkg::BURST_W'(1) : fqrrb_pkg::BURST_W'(1);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          fqrrb_pkg::REG_BURST_LIMIT: begin
            burst_limit <= cfg_data;
          end
          fqrrb_pkg::REG_START_LANE: begin
            cur_lane <= start_x[LSEL_W-1:0];
            served   <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result of the update cycle.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (kind_q == fqrrb_pkg::KIND_ENQUEUE) begin
        res_enq_ok   <= enq_ok;
        res_grant    <= 1'b0;
        res_lane     <= '0;
        res_switched <= 1'b0;
      end else begin
        res_enq_ok   <= 1'b0;
        res_grant    <= found;
        res_lane     <= found ? sel_x[fqrrb_pkg::LANE_W-1:0] : '0;
        res_switched <= found && switched;
      end
    end
  end

  // Output register; the store read data is valid from this cycle on.
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      enqueue_ok    <= res_enq_ok;
      grant_valid   <= res_grant;
      grant_lane    <= res_lane;
      grant_tag     <= res_grant ? rd_data[fqrrb_pkg::ENTRY_W-1:fqrrb_pkg::HOLD_W] : '0;
      grant_hold    <= res_grant ? rd_data[fqrrb_pkg::HOLD_W-1:0] : '0;
      lane_switched <= res_switched;
    end
  end

endmodule

// File: design/four_queue_round_robin_burst.sv
// Round-robin scheduler over LANES bounded FIFO queues with a burst quantum.
// An item with kind 0 appends {entry_tag, hold_time} to the queue of its lane
// and reports enqueue_ok (0 when the lane is full or out of range); an item
// with kind 1 grants the head entry of the lane being served, which keeps the
// grant until burst_limit grants have been made in its turn or it runs empty,
// after which service rotates to the next non-empty lane. Every item gives
// exactly one result beat. An item first updates the queue pointers and
// accesses the shared entry store, then loads the registered store read into
// the output register, during which the next item can be taken; a result
// beat left waiting on out_stall holds off the following one.
// The store is not cleared at reset: only written slots are ever granted.
module four_queue_round_robin_burst #(
  parameter int QUEUE_DEPTH = fqrrb_pkg::QUEUE_DEPTH_DEF,
  parameter int LANES       = fqrrb_pkg::LANES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fqrrb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fqrrb_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fqrrb_pkg::KIND_W-1:0]    kind,
  input  logic [fqrrb_pkg::LANE_W-1:0]    lane,
  input  logic [fqrrb_pkg::TAG_W-1:0]     entry_tag,
  input  logic [fqrrb_pkg::HOLD_W-1:0]    hold_time,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            enqueue_ok,
  output logic                            grant_valid,
  output logic [fqrrb_pkg::LANE_W-1:0]    grant_lane,
  output logic [fqrrb_pkg::TAG_W-1:0]     grant_tag,
  output logic [fqrrb_pkg::HOLD_W-1:0]    grant_hold,
  output logic                            lane_switched
);

  fqrrb_pkg::ctrl_cmd_t cmd;

  fqrrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  fqrrb_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LANES       (LANES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .kind          (kind),
    .lane          (lane),
    .entry_tag     (entry_tag),
    .hold_time     (hold_time),
    .enqueue_ok    (enqueue_ok),
    .grant_valid   (grant_valid),
    .grant_lane    (grant_lane),
    .grant_tag     (grant_tag),
    .grant_hold    (grant_hold),
    .lane_switched (lane_switched)
  );

endmodule

// File: bench/four_queue_round_robin_burst_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the configuration port of the scheduler, keeps its
// own copy of the four lane queues, and compares every result beat with the
// oldest predicted grant.
module four_queue_round_robin_burst_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fqrrb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fqrrb_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [fqrrb_pkg::KIND_W-1:0]    kind,
  input  logic [fqrrb_pkg::LANE_W-1:0]    lane,
  input  logic [fqrrb_pkg::TAG_W-1:0]     entry_tag,
  input  logic [fqrrb_pkg::HOLD_W-1:0]    hold_time,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            enqueue_ok,
  input  logic                            grant_valid,
  input  logic [fqrrb_pkg::LANE_W-1:0]    grant_lane,
  input  logic [fqrrb_pkg::TAG_W-1:0]     grant_tag,
  input  logic [fqrrb_pkg::HOLD_W-1:0]    grant_hold,
  input  logic                            lane_switched,
  output int                              pending,
  output int                              fail_count
);

  localparam int QDEPTH = fqrrb_pkg::QUEUE_DEPTH_DEF;
  localparam int NLANES = fqrrb_pkg::LANES_DEF;
  localparam int IDX_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic                         enq_ok;
    logic                         granted;
    logic [fqrrb_pkg::LANE_W-1:0] from_lane;
    logic [fqrrb_pkg::TAG_W-1:0]  tag;
    logic [fqrrb_pkg::HOLD_W-1:0] hold;
    logic                         switched;
  } grant_beat_t;

  // Shadow copy of the queues and the service pointer.
  logic [fqrrb_pkg::ENTRY_W-1:0] slots [NLANES][QDEPTH];
  logic [IDX_W-1:0]              heads [NLANES];
  logic [IDX_W-1:0]              tails [NLANES];
  logic [CNT_W-1:0]              held  [NLANES];
  logic [fqrrb_pkg::LANE_W-1:0]  cur_lane;
  logic [fqrrb_pkg::BURST_W-1:0] served;
  logic [fqrrb_pkg::BURST_W-1:0] burst_quota;

  grant_beat_t expected_grants[$];
  int          errors = 0;

  function automatic logic [IDX_W-1:0] bump_slot(logic [IDX_W-1:0] s);
    return (int'(s) + 1 >= QDEPTH) ? '0 : s + 1'b1;
  endfunction

  // One line per mismatch, and a count of them.
  task automatic report_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
    $display("%0t: %s: expected %0h, got %0h", $realtime, what, want_v, got_v);
    errors++;
  endtask

  // Applies one accepted input beat to the shadow queues and works out its result.
  task automatic predict_grant(input logic [fqrrb_pkg::KIND_W-1:0] k,
                               input logic [fqrrb_pkg::LANE_W-1:0] ln,
                               input logic [fqrrb_pkg::TAG_W-1:0] tg,
                               input logic [fqrrb_pkg::HOLD_W-1:0] hd,
                               output grant_beat_t r);
    logic                          found;
    logic                          sw;
    logic [fqrrb_pkg::LANE_W-1:0]  sel;
    logic [fqrrb_pkg::ENTRY_W-1:0] e;
    int                            cand;
    r     = '0;
    found = 1'b0;
    sw    = 1'b0;
    sel   = '0;
    if (k == fqrrb_pkg::KIND_ENQUEUE) begin
      if (int'(ln) < NLANES && int'(held[ln]) < QDEPTH) begin
        slots[ln][tails[ln]] = {tg, hd};
        tails[ln] = bump_slot(tails[ln]);
        held[ln]  = held[ln] + 1'b1;
        r.enq_ok  = 1'b1;
      end
    end else begin
      if (held[cur_lane] != 0 && served < burst_quota) begin
        // The lane keeps its turn.
        sel    = cur_lane;
        sw     = (served == 0);
        served = served + 1'b1;
        found  = 1'b1;
      end else begin
        // Rotate to the next lane holding entries, ending back at this one.
        for (int step = 1; step <= NLANES; step++) begin
          cand = (int'(cur_lane) + step) % NLANES;
          if (!found && held[cand] != 0) begin
            sel   = cand[fqrrb_pkg::LANE_W-1:0];
            found = 1'b1;
          end
        end
        if (found) begin
          cur_lane = sel;
          served   = fqrrb_pkg::BURST_W'(1);
          sw       = 1'b1;
        end
      end
      if (found) begin
        e           = slots[sel][heads[sel]];
        heads[sel]  = bump_slot(heads[sel]);
        held[sel]   = held[sel] - 1'b1;
        r.granted   = 1'b1;
        r.from_lane = sel;
        r.tag       = e[fqrrb_pkg::ENTRY_W-1:fqrrb_pkg::HOLD_W];
        r.hold      = e[fqrrb_pkg::HOLD_W-1:0];
        r.switched  = sw;
      end
    end
  endtask

  // Compare result beats first, then predict the input beat of the same edge.
  always @(posedge clk) begin : watch
    grant_beat_t want;
    grant_beat_t pred;
    if (rst) begin
      for (int l = 0; l < NLANES; l++) begin
        heads[l] = '0;
        tails[l] = '0;
        held[l]  = '0;
      end
      cur_lane    = '0;
      served      = '0;
      burst_quota = fqrrb_pkg::BURST_LIMIT_RST;
      expected_grants.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == fqrrb_pkg::REG_BURST_LIMIT) begin
          burst_quota = cfg_data[fqrrb_pkg::BURST_W-1:0];
        end else if (cfg_index == fqrrb_pkg::REG_START_LANE) begin
          cur_lane = cfg_data[fqrrb_pkg::LANE_W-1:0];
          served   = '0;
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("result beat with no grant pending", 32'd0, 32'd1);
        end else begin
          want = expected_grants.pop_front();
          if (enqueue_ok !== want.enq_ok)
            report_mismatch("enqueue_ok", 32'(want.enq_ok), 32'(enqueue_ok));
          if (grant_valid !== want.granted)
            report_mismatch("grant_valid", 32'(want.granted), 32'(grant_valid));
          if (grant_lane !== want.from_lane)
            report_mismatch("grant_lane", 32'(want.from_lane), 32'(grant_lane));
          if (grant_tag !== want.tag)
            report_mismatch("grant_tag", 32'(want.tag), 32'(grant_tag));
          if (grant_hold !== want.hold)
            report_mismatch("grant_hold", 32'(want.hold), 32'(grant_hold));
          if (lane_switched !== want.switched)
            report_mismatch("lane_switched", 32'(want.switched), 32'(lane_switched));
        end
      end
      if (in_valid && !in_stall) begin
        predict_grant(kind, lane, entry_tag, hold_time, pred);
        expected_grants.push_back(pred);
      end
    end
    pending    <= expected_grants.size();
    fail_count <= errors;
  end

endmodule

// File: bench/four_queue_round_robin_burst_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the round-robin burst scheduler; the checker beside
// the block does all prediction and comparison.
module four_queue_round_robin_burst_tb;

  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 400;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_we;
  logic [fqrrb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fqrrb_pkg::CFG_W-1:0]     cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [fqrrb_pkg::KIND_W-1:0]    kind;
  logic [fqrrb_pkg::LANE_W-1:0]    lane;
  logic [fqrrb_pkg::TAG_W-1:0]     entry_tag;
  logic [fqrrb_pkg::HOLD_W-1:0]    hold_time;
  logic                            out_valid;
  logic                            out_stall;
  logic                            enqueue_ok;
  logic                            grant_valid;
  logic [fqrrb_pkg::LANE_W-1:0]    grant_lane;
  logic [fqrrb_pkg::TAG_W-1:0]     grant_tag;
  logic [fqrrb_pkg::HOLD_W-1:0]    grant_hold;
  logic                            lane_switched;

  int pending;
  int fail_count;
  int hold_request = 0;
  int beats_left_in_burst = 4;

  four_queue_round_robin_burst uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .lane(lane), .entry_tag(entry_tag), .hold_time(hold_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .enqueue_ok(enqueue_ok), .grant_valid(grant_valid), .grant_lane(grant_lane),
    .grant_tag(grant_tag), .grant_hold(grant_hold), .lane_switched(lane_switched)
  );

  four_queue_round_robin_burst_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .lane(lane), .entry_tag(entry_tag), .hold_time(hold_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .enqueue_ok(enqueue_ok), .grant_valid(grant_valid), .grant_lane(grant_lane),
    .grant_tag(grant_tag), .grant_hold(grant_hold), .lane_switched(lane_switched),
    .pending(pending), .fail_count(fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one beat and wait for it to be taken; gaps come between bursts.
  task automatic send_beat(logic [fqrrb_pkg::KIND_W-1:0] k, logic [fqrrb_pkg::LANE_W-1:0] ln,
                           logic [fqrrb_pkg::TAG_W-1:0] tg, logic [fqrrb_pkg::HOLD_W-1:0] hd);
    in_valid  <= 1'b1;
    kind      <= k;
    lane      <= ln;
    entry_tag <= tg;
    hold_time <= hd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (beats_left_in_burst == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      beats_left_in_burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 10);
    end else begin
      beats_left_in_burst--;
    end
  endtask

  task automatic send_serve();
    send_beat(fqrrb_pkg::KIND_SERVE, fqrrb_pkg::LANE_W'($urandom_range(0, 3)),
              fqrrb_pkg::TAG_W'($urandom_range(0, 65535)),
              fqrrb_pkg::HOLD_W'($urandom_range(0, 15)));
  endtask

  // Stop offering and wait until every predicted grant has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [fqrrb_pkg::CFG_IDX_W-1:0] idx,
                           logic [fqrrb_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // One random phase: set both registers, then a mix of enqueues and serves.
  task automatic run_phase(logic [fqrrb_pkg::BURST_W-1:0] quota,
                           logic [fqrrb_pkg::LANE_W-1:0] first_lane,
                           int beats, int enq_pct, int focus_pct, bit pause_mid);
    logic [fqrrb_pkg::LANE_W-1:0] focus;
    logic [fqrrb_pkg::LANE_W-1:0] ln;
    drain();
    write_reg(fqrrb_pkg::REG_BURST_LIMIT, quota);
    write_reg(fqrrb_pkg::REG_START_LANE, {6'($urandom_range(0, 63)), first_lane});
    focus = fqrrb_pkg::LANE_W'($urandom_range(0, 3));
    for (int i = 0; i < beats; i++) begin
      if (pause_mid && i == beats / 2)
        drain();
      if ($urandom_range(1, 100) <= enq_pct) begin
        ln = ($urandom_range(1, 100) <= focus_pct) ? focus : 2'($urandom_range(0, 3));
        send_beat(fqrrb_pkg::KIND_ENQUEUE, ln, fqrrb_pkg::TAG_W'($urandom_range(0, 65535)),
                  fqrrb_pkg::HOLD_W'($urandom_range(0, 15)));
      end else begin
        send_serve();
      end
    end
  endtask

  // Receiver stall: modes of random length, plus a long hold-off on request.
  initial begin : receiver
    int hold_seen;
    int hold_left;
    int mode;
    int mode_left;
    hold_seen = 0;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_request != hold_seen) begin
        hold_seen = hold_request;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(1, 100) <= 25);
          2: out_stall <= ($urandom_range(1, 100) <= 70);
          default: out_stall <= mode_left[0];
        endcase
      end
    end
  end

  // Watchdog: too many cycles in a row with no beat on either channel.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= fqrrb_pkg::REG_BURST_LIMIT;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    kind      <= fqrrb_pkg::KIND_ENQUEUE;
    lane      <= '0;
    entry_tag <= '0;
    hold_time <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: serve with all lanes empty, then one entry per lane and a second for lane 0.
    send_serve();
    send_beat(fqrrb_pkg::KIND_ENQUEUE, 2'd0, 16'h0000, 4'd0);
    send_beat(fqrrb_pkg::KIND_ENQUEUE, 2'd1, 16'hFFFF, 4'd15);
    send_beat(fqrrb_pkg::KIND_ENQUEUE, 2'd2, 16'h1234, 4'd9);
    send_beat(fqrrb_pkg::KIND_ENQUEUE, 2'd3, 16'hA5A5, 4'd10);
    send_beat(fqrrb_pkg::KIND_ENQUEUE, 2'd0, 16'h5A5A, 4'd15);
    repeat (6) send_serve();

    // Burst limit zero, start lane written with its upper bits set.
    drain();
    write_reg(fqrrb_pkg::REG_BURST_LIMIT, 8'd0);
    write_reg(fqrrb_pkg::REG_START_LANE, 8'hFF);
    send_beat(fqrrb_pkg::KIND_ENQUEUE, 2'd0, 16'h0F0F, 4'd1);
    send_beat(fqrrb_pkg::KIND_ENQUEUE, 2'd0, 16'hF0F0, 4'd14);
    send_beat(fqrrb_pkg::KIND_ENQUEUE, 2'd3, 16'h8001, 4'd8);
    repeat (4) send_serve();

    // Largest burst limit: one lane keeps its turn until it runs dry.
    drain();
    write_reg(fqrrb_pkg::REG_BURST_LIMIT, 8'd255);
    write_reg(fqrrb_pkg::REG_START_LANE, 8'd1);
    send_beat(fqrrb_pkg::KIND_ENQUEUE, 2'd1, 16'h7FFF, 4'd7);
    send_beat(fqrrb_pkg::KIND_ENQUEUE, 2'd1, 16'h8000, 4'd12);
    send_beat(fqrrb_pkg::KIND_ENQUEUE, 2'd2, 16'h00FF, 4'd3);
    send_beat(fqrrb_pkg::KIND_ENQUEUE, 2'd1, 16'hFF00, 4'd0);
    repeat (5) send_serve();

    run_phase(8'd1, 2'd0, 80, 55, 0, 1'b0);
    run_phase(8'd2, 2'd1, 80, 60, 50, 1'b0);
    // Flood one lane past full while the receiver holds off for a long stretch.
    drain();
    hold_request <= hold_request + 1;
    run_phase(8'd255, 2'd3, 150, 100, 100, 1'b0);
    run_phase(8'd0, 2'd2, 150, 15, 0, 1'b0);
    run_phase(8'($urandom_range(3, 8)), 2'($urandom_range(0, 3)), 100, 50, 0, 1'b1);
    run_phase(8'd128, 2'($urandom_range(0, 3)), 80, 45, 30, 1'b0);
    run_phase(8'd4, 2'($urandom_range(0, 3)), 80, 50, 60, 1'b0);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
